// File: rtl/ogm_pkg.sv
// ogm_pkg: shared types, codes and defaults for the occupancy grid block
// used by the top module and the testbench, depends on nothing

package ogm_pkg;

    localparam int MAP_CELLS_DEF   = 64;
    localparam int ORIGIN_CELL_DEF = 32;
    localparam int MAX_REACH_DEF   = 15;

    localparam logic [15:0] CPM_RESET = 16'd2560;

    localparam logic [1:0] CELL_UNKNOWN = 2'd0;
    localparam logic [1:0] CELL_FREE    = 2'd1;
    localparam logic [1:0] CELL_OCC     = 2'd2;

    localparam logic [1:0] FUNC_MARK  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_MERGE = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic [15:0]        radius;
        logic [1:0]         mark_value;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
    } item_t;

    typedef struct packed {
        logic occupied;
        logic status;
        logic map_changed;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_R,
        S_CHECK,
        S_WALK,
        S_DRAIN,
        S_QREAD,
        S_QRES,
        S_MREAD,
        S_MWRITE,
        S_FINISH
    } ogm_state_t;

    // code three counts as occupied
    function automatic logic [1:0] clamp_code(input logic [1:0] v);
        clamp_code = (v == 2'd3) ? CELL_OCC : v;
    endfunction

endpackage

// File: rtl/ogm_mult.sv
// ogm_mult: shared 16x16 unsigned multiplier with a registered product
// no dependencies

module ogm_mult
(
    input  logic        clk,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [31:0] p
);

    logic [31:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 32'(a) * 32'(b);
    end

    assign p = p_reg;

endmodule

// File: rtl/ogm_grid_ram.sv
// ogm_grid_ram: grid cell memory, one write port and one registered read port
// no dependencies

module ogm_grid_ram
#(
    parameter int AW = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    logic [1:0] mem [2**AW];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/occupancy_grid_mark_and_query.sv
// Occupancy grid map with mark, query and merge. After reset the block sweeps the grid memory
// to unknown, one cell per cycle, over all (2**clog2(MAP_CELLS))**2 cells (4096 at the default
// size), and stalls items meanwhile; configuration writes are taken during the sweep and
// between items, never while an item is being worked. Then one item is worked at a time and
// the next word is taken in the idle state that the block enters as the result is loaded.
// The diamond walk of a mark visits one grid position per cycle through the single read and
// single write port of the grid memory. A position outside the map ends a mark or query, and
// a bad merge address a merge, before any grid memory access; a result word still stalled at
// the output adds its wait.
// Positions are scaled through one shared 16x16 multiplier, used once for x, once for y and
// once for the radius.
// Depends on ogm_pkg, ogm_mult and ogm_grid_ram.

module occupancy_grid_mark_and_query
#(
    parameter int MAP_CELLS   = ogm_pkg::MAP_CELLS_DEF,
    parameter int ORIGIN_CELL = ogm_pkg::ORIGIN_CELL_DEF,
    parameter int MAX_REACH   = ogm_pkg::MAX_REACH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ogm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ogm_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);

    localparam int CW = $clog2(MAP_CELLS);
    localparam int AW = 2 * CW;
    localparam int OW = $clog2(MAX_REACH + 1) + 1;
    localparam int DW = OW + 1;
    localparam int PW = 20;

    ogm_pkg::ogm_state_t state_reg, state_next;
    ogm_pkg::item_t      item_reg, item_next;
    ogm_pkg::result_t    res_reg, res_next;

    logic [15:0]          cpm_reg;
    logic [CW-1:0]        xc_reg, xc_next;
    logic [CW-1:0]        yc_reg, yc_next;
    logic                 xin_reg, xin_next;
    logic                 yin_reg, yin_next;
    logic [OW-1:0]        reach_reg, reach_next;
    logic signed [OW-1:0] dr_reg, dr_next;
    logic signed [OW-1:0] dc_reg, dc_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic                 wrote_reg, wrote_next;
    logic                 occ_reg, occ_next;
    logic                 status_reg, status_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                 res_valid_reg, res_valid_next;

    logic [15:0]          mul_a;
    logic [31:0]          mul_p;
    logic [31:0]          rnd;
    logic                 cell_neg;
    logic signed [PW-1:0] cell_pos;
    logic                 cell_in;
    logic [OW-1:0]        reach_c;
    logic [15:0]          reach_hi;

    logic signed [PW-1:0] yy;
    logic signed [PW-1:0] xx;
    logic signed [PW-1:0] row_w;
    logic [OW-1:0]        adr;
    logic [OW-1:0]        adc;
    logic [DW-1:0]        manh_dist;
    logic                 walk_ok;
    logic [AW-1:0]        walk_addr;
    logic                 last_col;
    logic                 last_row;
    logic signed [OW-1:0] reach_s;

    logic [1:0]           val;
    logic [AW-1:0]        query_addr;
    logic [AW-1:0]        merge_addr;
    logic                 merge_bad;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [1:0]           ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [1:0]           ram_rdata;

    ogm_mult u_mult
    (
        .clk (clk),
        .a   (mul_a),
        .b   (cpm_reg),
        .p   (mul_p)
    );

    ogm_grid_ram #(.AW(AW)) u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpm_reg <= ogm_pkg::CPM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cpm_reg <= cfg_data;
        end
    end

    assign cfg_ready = (state_reg == ogm_pkg::S_IDLE) || (state_reg == ogm_pkg::S_CLEAR);

    // multiplier operand and position to cell
    always_comb
    begin
        unique case (state_reg)
            ogm_pkg::S_MUL_X:
                mul_a = item_reg.x_pos[15] ? 16'(-item_reg.x_pos) : 16'(item_reg.x_pos);
            ogm_pkg::S_MUL_Y:
                mul_a = item_reg.y_pos[15] ? 16'(-item_reg.y_pos) : 16'(item_reg.y_pos);
            default:
                mul_a = item_reg.radius;
        endcase
    end

    assign cell_neg = (state_reg == ogm_pkg::S_MUL_Y) ? item_reg.x_pos[15] : item_reg.y_pos[15];
    assign rnd      = mul_p + 32'h0000_8000;
    assign cell_pos = (cell_neg ? -$signed(PW'(rnd[31:16])) : $signed(PW'(rnd[31:16])))
                      + $signed(PW'(ORIGIN_CELL));
    assign cell_in  = (cell_pos >= 0) && (cell_pos < $signed(PW'(MAP_CELLS)));

    assign reach_hi = mul_p[31:16];
    assign reach_c  = (reach_hi >= 16'(MAX_REACH)) ? OW'(MAX_REACH) : OW'(reach_hi) + OW'(1);
    assign reach_s  = $signed(reach_reg);

    // diamond walk position
    assign yy    = $signed(PW'(yc_reg)) + PW'(dr_reg);
    assign xx    = $signed(PW'(xc_reg)) + PW'(dc_reg);
    assign row_w = $signed(PW'(MAP_CELLS - 1)) - yy;
    assign adr   = dr_reg[OW-1] ? OW'(-dr_reg) : OW'(dr_reg);
    assign adc   = dc_reg[OW-1] ? OW'(-dc_reg) : OW'(dc_reg);
    assign manh_dist = DW'(adr) + DW'(adc);
    assign walk_ok = (yy >= 0) && (yy < $signed(PW'(MAP_CELLS)))
                     && (xx >= 0) && (xx < $signed(PW'(MAP_CELLS)))
                     && (manh_dist <= DW'(reach_reg) + DW'(1));
    assign walk_addr = {row_w[CW-1:0], xx[CW-1:0]};
    assign last_col  = (dc_reg == reach_s);
    assign last_row  = (dr_reg == reach_s);

    assign val        = ogm_pkg::clamp_code(item_reg.mark_value);
    assign query_addr = {CW'(MAP_CELLS - 1) - yc_reg, xc_reg};
    assign merge_addr = {CW'(item_reg.cell_row), CW'(item_reg.cell_col)};
    assign merge_bad  = (PW'(item_reg.cell_row) >= PW'(MAP_CELLS))
                        || (PW'(item_reg.cell_col) >= PW'(MAP_CELLS));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ogm_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        xc_reg        <= xc_next;
        yc_reg        <= yc_next;
        xin_reg       <= xin_next;
        yin_reg       <= yin_next;
        reach_reg     <= reach_next;
        dr_reg        <= dr_next;
        dc_reg        <= dc_next;
        pend_addr_reg <= pend_addr_next;
        wrote_reg     <= wrote_next;
        occ_reg       <= occ_next;
        status_reg    <= status_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        xc_next        = xc_reg;
        yc_next        = yc_reg;
        xin_next       = xin_reg;
        yin_next       = yin_reg;
        reach_next     = reach_reg;
        dr_next        = dr_reg;
        dc_next        = dc_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        wrote_next     = wrote_reg;
        occ_next       = occ_reg;
        status_next    = status_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_valid_next = res_valid_reg && result_stall;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = val;
        ram_re    = 1'b0;
        ram_raddr = walk_addr;

        // pending write from the walk, made in the cycle after its read
        if ((state_reg == ogm_pkg::S_WALK || state_reg == ogm_pkg::S_DRAIN)
            && pend_reg && ram_rdata != ogm_pkg::CELL_OCC)
        begin
            ram_we     = 1'b1;
            wrote_next = 1'b1;
        end

        unique case (state_reg)
            ogm_pkg::S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = ogm_pkg::CELL_UNKNOWN;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ogm_pkg::S_IDLE;
                end
            end
            ogm_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next   = item;
                    wrote_next  = 1'b0;
                    occ_next    = 1'b0;
                    status_next = 1'b0;
                    unique case (item.func)
                        ogm_pkg::FUNC_MARK,
                        ogm_pkg::FUNC_QUERY: state_next = ogm_pkg::S_MUL_X;
                        ogm_pkg::FUNC_MERGE: state_next = ogm_pkg::S_MREAD;
                        default:             state_next = ogm_pkg::S_FINISH;
                    endcase
                end
            end
            ogm_pkg::S_MUL_X:
            begin
                state_next = ogm_pkg::S_MUL_Y;
            end
            ogm_pkg::S_MUL_Y:
            begin
                xc_next    = cell_pos[CW-1:0];
                xin_next   = cell_in;
                state_next = ogm_pkg::S_MUL_R;
            end
            ogm_pkg::S_MUL_R:
            begin
                yc_next    = cell_pos[CW-1:0];
                yin_next   = cell_in;
                state_next = ogm_pkg::S_CHECK;
            end
            ogm_pkg::S_CHECK:
            begin
                reach_next = reach_c;
                dr_next    = -$signed(reach_c);
                dc_next    = -$signed(reach_c);
                if (!(xin_reg && yin_reg))
                begin
                    status_next = 1'b1;
                    state_next  = ogm_pkg::S_FINISH;
                end
                else if (item_reg.func == ogm_pkg::FUNC_QUERY)
                begin
                    state_next = ogm_pkg::S_QREAD;
                end
                else
                begin
                    state_next = ogm_pkg::S_WALK;
                end
            end
            ogm_pkg::S_WALK:
            begin
                ram_re         = walk_ok;
                ram_raddr      = walk_addr;
                pend_next      = walk_ok;
                pend_addr_next = walk_addr;
                if (last_col)
                begin
                    dc_next = -reach_s;
                    dr_next = dr_reg + OW'(1);
                    if (last_row)
                    begin
                        state_next = ogm_pkg::S_DRAIN;
                    end
                end
                else
                begin
                    dc_next = dc_reg + OW'(1);
                end
            end
            ogm_pkg::S_DRAIN:
            begin
                state_next = ogm_pkg::S_FINISH;
            end
            ogm_pkg::S_QREAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = query_addr;
                state_next = ogm_pkg::S_QRES;
            end
            ogm_pkg::S_QRES:
            begin
                occ_next   = (ram_rdata == ogm_pkg::CELL_OCC);
                state_next = ogm_pkg::S_FINISH;
            end
            ogm_pkg::S_MREAD:
            begin
                if (merge_bad)
                begin
                    status_next = 1'b1;
                    state_next  = ogm_pkg::S_FINISH;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = merge_addr;
                    state_next = ogm_pkg::S_MWRITE;
                end
            end
            ogm_pkg::S_MWRITE:
            begin
                ram_waddr = merge_addr;
                if (val == ogm_pkg::CELL_OCC)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ogm_pkg::CELL_OCC;
                end
                else if (val == ogm_pkg::CELL_FREE && ram_rdata == ogm_pkg::CELL_UNKNOWN)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ogm_pkg::CELL_FREE;
                end
                state_next = ogm_pkg::S_FINISH;
            end
            ogm_pkg::S_FINISH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next.occupied    = occ_reg;
                    res_next.status      = status_reg;
                    res_next.map_changed = wrote_reg && (val == ogm_pkg::CELL_OCC)
                                           && (item_reg.func == ogm_pkg::FUNC_MARK);
                    res_valid_next       = 1'b1;
                    state_next           = ogm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ogm_pkg::S_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != ogm_pkg::S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_word_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ogm_pkg::S_FINISH))
        else $error("result word appeared without a finished item");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> state_reg != ogm_pkg::S_IDLE)
        else $error("accepted word did not start work");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.status && (result.map_changed || result.occupied)))
        else $error("error status with a query or mark outcome");

    a_walk_in_reach: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ogm_pkg::S_WALK |-> (dr_reg <= reach_s) && (dr_reg >= -reach_s))
        else $error("walk row offset outside reach");

endmodule

// File: tb/sv/testbench.sv
// testbench for occupancy_grid_mark_and_query: a queue-fed driver and a monitor check every
// result against a cycle-free model of the grid map, over several scale settings
// depends on ogm_pkg and the block's rtl only
`timescale 1ns / 100ps

module testbench;

    localparam int CELLS         = ogm_pkg::MAP_CELLS_DEF;
    localparam int ORIGIN        = ogm_pkg::ORIGIN_CELL_DEF;
    localparam int REACH_CAP     = ogm_pkg::MAX_REACH_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 64;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [1:0] CELL_THREE = 2'd3;

    typedef enum logic [1:0] {
        STEP_WORD,
        STEP_DRAIN,
        STEP_SCALE
    } step_kind_t;

    typedef struct {
        step_kind_t     kind;
        ogm_pkg::item_t word;
        logic [15:0]    scale;
    } step_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    ogm_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    ogm_pkg::result_t result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [15:0]      cfg_data     = '0;

    step_t            pending_steps[$];
    ogm_pkg::result_t expected_results[$];
    logic [1:0]       map_copy [CELLS*CELLS];
    logic [15:0]      scale_copy;
    int               errors       = 0;

    int               gap_in       = 0;
    int               settle_left  = SETTLE_CYCLES;
    int               calm_left_in = 0;
    bit               calm_in      = 1'b0;
    int               run_out      = 0;
    int               calm_left_out = 0;
    bit               calm_out     = 1'b0;

    occupancy_grid_mark_and_query u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------- grid model

    function automatic bit on_map(int v);
        return v >= 0 && v < CELLS;
    endfunction

    function automatic int to_cell(logic signed [15:0] pos, logic [15:0] cpm);
        longint p;
        longint mag;
        longint q;
        p   = pos;
        mag = ((p < 0) ? -p : p) * longint'(cpm);
        q   = (mag + 32768) >>> 16;
        return int'((p < 0) ? -q : q) + ORIGIN;
    endfunction

    function automatic logic [1:0] cell_code(logic [1:0] v);
        return (v == CELL_THREE) ? ogm_pkg::CELL_OCC : v;
    endfunction

    task automatic grid_predict(input ogm_pkg::item_t w, output ogm_pkg::result_t r);
        int         xc;
        int         yc;
        int         reach;
        int         dr;
        int         dc;
        int         idx;
        longint     prod;
        logic [1:0] val;
        bit         wrote;
        r = '0;
        case (w.func)
            ogm_pkg::FUNC_MARK, ogm_pkg::FUNC_QUERY:
            begin
                xc = to_cell(w.x_pos, scale_copy);
                yc = to_cell(w.y_pos, scale_copy);
                if (!on_map(xc) || !on_map(yc))
                begin
                    r.status = 1'b1;
                end
                else if (w.func == ogm_pkg::FUNC_QUERY)
                begin
                    r.occupied = (map_copy[(CELLS - 1 - yc) * CELLS + xc]
                                  == ogm_pkg::CELL_OCC);
                end
                else
                begin
                    val   = cell_code(w.mark_value);
                    prod  = longint'(w.radius) * longint'(scale_copy);
                    reach = int'(prod >>> 16) + 1;
                    if (reach > REACH_CAP)
                        reach = REACH_CAP;
                    wrote = 1'b0;
                    for (dr = -reach; dr <= reach; dr++)
                    begin
                        for (dc = -reach; dc <= reach; dc++)
                        begin
                            if (on_map(yc + dr) && on_map(xc + dc) &&
                                ((dr < 0) ? -dr : dr) + ((dc < 0) ? -dc : dc) <= reach + 1)
                            begin
                                idx = (CELLS - 1 - (yc + dr)) * CELLS + xc + dc;
                                // occupied cells are never overwritten by a mark
                                if (map_copy[idx] != ogm_pkg::CELL_OCC)
                                begin
                                    map_copy[idx] = val;
                                    wrote = 1'b1;
                                end
                            end
                        end
                    end
                    r.map_changed = wrote && (val == ogm_pkg::CELL_OCC);
                end
            end
            ogm_pkg::FUNC_MERGE:
            begin
                if (int'(w.cell_row) >= CELLS || int'(w.cell_col) >= CELLS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    idx = int'(w.cell_row) * CELLS + int'(w.cell_col);
                    val = cell_code(w.mark_value);
                    if (val == ogm_pkg::CELL_OCC)
                        map_copy[idx] = ogm_pkg::CELL_OCC;
                    else if (val == ogm_pkg::CELL_FREE && map_copy[idx] == ogm_pkg::CELL_UNKNOWN)
                        map_copy[idx] = ogm_pkg::CELL_FREE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus

    // raw position that lands near cell offset d from the origin
    function automatic logic signed [15:0] pos_for(int d, logic [15:0] cpm, bit jitter);
        longint v;
        longint w;
        if (cpm == 16'd0)
            return 16'($urandom);
        v = (longint'(d) * 65536) / longint'(cpm);
        w = 65536 / longint'(cpm);
        if (jitter)
            v = v + longint'($urandom_range(0, int'(w))) - w / 2;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] radius_for(int extra, logic [15:0] cpm);
        longint v;
        if (cpm == 16'd0)
            return 16'($urandom);
        v = (longint'(extra) * 65536) / longint'(cpm) +
            longint'($urandom_range(0, 65535 / int'(cpm)));
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    function automatic ogm_pkg::item_t make_word(logic [1:0] func, logic signed [15:0] x,
                                                 logic signed [15:0] y, logic [15:0] radius,
                                                 logic [1:0] val, logic [5:0] row,
                                                 logic [5:0] col);
        ogm_pkg::item_t w;
        w.func       = func;
        w.x_pos      = x;
        w.y_pos      = y;
        w.radius     = radius;
        w.mark_value = val;
        w.cell_row   = row;
        w.cell_col   = col;
        return w;
    endfunction

    function automatic ogm_pkg::item_t random_word(logic [15:0] cpm);
        ogm_pkg::item_t w;
        int             pick;
        w    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        // a few words are pure noise, spare function code included
        if (pick < 8)
            return w;
        if (pick < 40)
            w.func = ogm_pkg::FUNC_MARK;
        else if (pick < 70)
            w.func = ogm_pkg::FUNC_QUERY;
        else
            w.func = ogm_pkg::FUNC_MERGE;
        if ($urandom_range(0, 99) < 88)
        begin
            w.x_pos = pos_for(int'($urandom_range(0, CELLS - 1)) - ORIGIN, cpm, 1'b1);
            w.y_pos = pos_for(int'($urandom_range(0, CELLS - 1)) - ORIGIN, cpm, 1'b1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 85)
            w.radius = radius_for(int'($urandom_range(0, 2)), cpm);
        else if (pick < 95)
            w.radius = radius_for(int'($urandom_range(3, 9)), cpm);
        return w;
    endfunction

    task automatic add_step(step_kind_t k, ogm_pkg::item_t w, logic [15:0] v);
        step_t s;
        s.kind        = k;
        s.word        = w;
        s.scale       = v;
        pending_steps = {pending_steps, s};
    endtask

    task automatic add_word(ogm_pkg::item_t w);
        add_step(STEP_WORD, w, 16'd0);
    endtask

    task automatic add_drain();
        add_step(STEP_DRAIN, '0, 16'd0);
    endtask

    task automatic add_scale(logic [15:0] v);
        add_step(STEP_SCALE, '0, v);
    endtask

    task automatic add_random(int n, logic [15:0] cpm);
        repeat (n) add_word(random_word(cpm));
    endtask

    function automatic int draw_gap(bit calm);
        int p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin : drive
        logic             next_valid;
        logic             next_cfg;
        ogm_pkg::result_t due;
        if (rst_n)
        begin
            next_valid = item_valid;
            next_cfg   = cfg_valid;
            if (item_valid && !item_stall)
            begin
                grid_predict(item, due);
                expected_results = {expected_results, due};
                next_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                scale_copy = cfg_data;
                next_cfg   = 1'b0;
            end
            if (calm_left_in == 0)
            begin
                calm_in      = ($urandom_range(0, 3) == 0);
                calm_left_in = $urandom_range(100, 400);
            end
            else
            begin
                calm_left_in--;
            end
            if (!next_valid && !next_cfg && pending_steps.size() != 0)
            begin
                if (gap_in > 0)
                begin
                    gap_in--;
                end
                else
                begin
                    case (pending_steps[0].kind)
                        STEP_WORD:
                        begin
                            item       <= pending_steps[0].word;
                            next_valid = 1'b1;
                            gap_in     = draw_gap(calm_in);
                            void'(pending_steps.pop_front());
                        end
                        STEP_SCALE:
                        begin
                            cfg_data <= pending_steps[0].scale;
                            next_cfg = 1'b1;
                            void'(pending_steps.pop_front());
                        end
                        default:
                        begin
                            // hold off until every word in flight has its result
                            if (expected_results.size() != 0)
                            begin
                                settle_left = SETTLE_CYCLES;
                            end
                            else if (settle_left > 0)
                            begin
                                settle_left--;
                            end
                            else
                            begin
                                settle_left = SETTLE_CYCLES;
                                void'(pending_steps.pop_front());
                            end
                        end
                    endcase
                end
            end
            item_valid <= next_valid;
            cfg_valid  <= next_cfg;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : watch
        ogm_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word %b", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.occupied !== want.occupied || result.status !== want.status ||
                        result.map_changed !== want.map_changed)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %b %b %b, got %b %b %b",
                                     want.occupied, want.status, want.map_changed,
                                     result.occupied, result.status, result.map_changed);
                    end
                end
            end
            if (calm_left_out == 0)
            begin
                calm_out      = ($urandom_range(0, 3) == 0);
                calm_left_out = $urandom_range(100, 400);
            end
            else
            begin
                calm_left_out--;
            end
            if (run_out > 0)
            begin
                run_out--;
            end
            else if (result_stall)
            begin
                result_stall <= 1'b0;
                run_out = $urandom_range(0, 6);
            end
            else
            begin
                run_out = draw_gap(calm_out);
                if (run_out > 0)
                begin
                    result_stall <= 1'b1;
                    run_out--;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : sequence_main
        logic [15:0] cpm;
        logic [15:0] boot;
        boot = ogm_pkg::CPM_RESET;
        foreach (map_copy[i])
            map_copy[i] = ogm_pkg::CELL_UNKNOWN;
        scale_copy = ogm_pkg::CPM_RESET;

        add_scale(boot);
        // origin: empty, marked, then a free mark that cannot clear it
        add_word(make_word(ogm_pkg::FUNC_QUERY, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_MARK, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_OCC, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_MARK, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_FREE, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, pos_for(1, boot, 1'b0), 16'sd0, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        // corners with reach clipped by the map edge and by the cap
        add_word(make_word(ogm_pkg::FUNC_MARK, pos_for(-32, boot, 1'b0),
                           pos_for(-32, boot, 1'b0), 16'hFFFF, CELL_THREE, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_MARK, pos_for(31, boot, 1'b0),
                           pos_for(31, boot, 1'b0), 16'd512, ogm_pkg::CELL_OCC, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, pos_for(31, boot, 1'b0),
                           pos_for(31, boot, 1'b0), 16'd0, ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        // just outside the map past the high x edge and the low y edge, then far outside on those sides
        add_word(make_word(ogm_pkg::FUNC_MARK, pos_for(32, boot, 1'b0), 16'sd0, 16'd0,
                           ogm_pkg::CELL_OCC, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_MARK, 16'sd0, pos_for(-33, boot, 1'b0), 16'd0,
                           ogm_pkg::CELL_OCC, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, 16'sd32767, 16'sd0, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, 16'sd0, -16'sd32768, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        // merges: occupied wins, free fills unknown only, code three
        add_word(make_word(ogm_pkg::FUNC_MERGE, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_OCC, 6'd5, 6'd7));
        add_word(make_word(ogm_pkg::FUNC_QUERY, pos_for(7 - ORIGIN, boot, 1'b0),
                           pos_for(58 - ORIGIN, boot, 1'b0), 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_MERGE, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_FREE, 6'd6, 6'd7));
        add_word(make_word(ogm_pkg::FUNC_MERGE, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_FREE, 6'd5, 6'd7));
        add_word(make_word(ogm_pkg::FUNC_MERGE, 16'sd0, 16'sd0, 16'd0,
                           CELL_THREE, 6'd6, 6'd7));
        add_word(make_word(ogm_pkg::FUNC_QUERY, pos_for(7 - ORIGIN, boot, 1'b0),
                           pos_for(57 - ORIGIN, boot, 1'b0), 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_MERGE, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_MERGE, 16'sd0, 16'sd0, 16'd0,
                           ogm_pkg::CELL_FREE, 6'd63, 6'd63));
        // spare function code, every field at its top
        add_word(make_word(FUNC_SPARE, -16'sd1, -16'sd1, 16'hFFFF, CELL_THREE, 6'd63, 6'd63));
        add_word(make_word(ogm_pkg::FUNC_MARK, pos_for(10, boot, 1'b0),
                           pos_for(10, boot, 1'b0), 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_drain();
        add_random(150, boot);
        add_drain();
        add_random(150, boot);

        add_drain();
        add_scale(16'hFFFF);
        add_random(150, 16'hFFFF);

        add_drain();
        add_scale(16'd1);
        add_random(100, 16'd1);

        // zero scale: everything lands on the origin cell
        add_drain();
        add_scale(16'd0);
        add_word(make_word(ogm_pkg::FUNC_MARK, 16'($urandom), 16'($urandom), 16'hFFFF,
                           ogm_pkg::CELL_OCC, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, 16'($urandom), 16'($urandom), 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_random(60, 16'd0);

        // one cell per meter: rounding halfway away from zero
        add_drain();
        add_scale(16'd256);
        add_word(make_word(ogm_pkg::FUNC_MARK, 16'sd128, -16'sd128, 16'd0,
                           ogm_pkg::CELL_OCC, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, 16'sd127, -16'sd128, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, -16'sd128, 16'sd127, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_word(make_word(ogm_pkg::FUNC_QUERY, 16'sd128, -16'sd129, 16'd0,
                           ogm_pkg::CELL_UNKNOWN, 6'd0, 6'd0));
        add_random(200, 16'd256);

        cpm = 16'($urandom_range(1, 65535));
        add_drain();
        add_scale(cpm);
        add_random(140, cpm);
        add_drain();
        add_random(150, cpm);

        while (pending_steps.size() != 0 || item_valid || cfg_valid ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        errors += expected_results.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
